@@ hdl/altitude_pid_with_auto_land_macros.svh @@
// Assertion macros shared by the altitude controller RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ALTITUDE_PID_WITH_AUTO_LAND_MACROS_SVH
`define ALTITUDE_PID_WITH_AUTO_LAND_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define APL_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("altitude controller check failed");
// next-cycle implication
`define APL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("altitude controller check failed");
`else
`define APL_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define APL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ hdl/apl_pkg.sv @@
// Package for the altitude controller: constants, register codes, shared types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package apl_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_GAIN_P     = 2'd0,
      CSR_GAIN_I     = 2'd1,
      CSR_GAIN_D     = 2'd2,
      CSR_ALT_ENABLE = 2'd3
   } csr_index_type;

   // PID limits (Q8.8 where noted)
   localparam logic signed [15:0] HOLD_ABOVE   = 16'sd300;
   localparam logic signed [12:0] INTEG_LIM_Q  = 13'sd2560;
   localparam logic signed [13:0] OUT_LIM_Q    = 14'sd5120;

   // landing sequence
   localparam logic [13:0]        LAND_STEP_MS     = 14'd5;
   localparam logic [13:0]        LAND_TIMEOUT_MS  = 14'd10000;
   localparam logic signed [15:0] LAND_DONE_HEIGHT = 16'sd5;
   localparam logic signed [15:0] LAND_FAST_HEIGHT = 16'sd100;
   localparam logic signed [15:0] LAND_MID_HEIGHT  = 16'sd30;
   localparam logic signed [5:0]  RATE_FAST        = -6'sd30;
   localparam logic signed [5:0]  RATE_MID         = -6'sd15;
   localparam logic signed [5:0]  RATE_SLOW        = -6'sd9;

   // PID state that the loop carries from tick to tick
   typedef struct packed {
      logic signed [16:0] prev_error;
      logic signed [31:0] error_sum;
   } pid_state_type;

   // landing sequencer decision for one tick
   typedef struct packed {
      logic              override;
      logic signed [5:0] cmd;
      logic              active;
      logic              lock;
      logic [13:0]       timer;
   } land_type;

endpackage

@@ hdl/altitude_pid_with_auto_land.sv @@
// Altitude controller top: item register, loop state, command select, result register.
// Depends on apl_pkg, apl_pid, apl_land and altitude_pid_with_auto_land_macros.svh.
//
//   port group  dir  handshake            payload
//   req_*       in   req_tvalid/tready    tdata: measured, target; tuser: start_landing
//   rsp_*       out  rsp_tvalid/tready    tdata: climb_rate; tuser: landing_active, lock
//   csr_*       in   csr_we               csr_index, csr_wdata
//
// An item is registered on accept in the item register and moves on into the result register;
// one item per cycle sustained while rsp_tready is held high.
// The loop state (accumulator, last error, held command, landing timer) is updated
// in the same cycle the item moves into the result register.
// A stalled result holds the item register; req_tready follows rsp_tready then.
// Reset is synchronous and clears configuration, valid flags and loop state to zero; payload registers are not reset.
`timescale 1ns / 1ps
`include "altitude_pid_with_auto_land_macros.svh"

module altitude_pid_with_auto_land (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] measured_height, [31:16] target_height
   input  logic        req_tuser,   // [0] start_landing
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] climb_rate, [7:6] zero
   output logic [1:0]  rsp_tuser,   // [0] landing_active, [1] lock_request
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration
   logic signed [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic               alt_enable_ff;

   // item register
   logic               s1_valid_ff, s1_valid_in;
   logic signed [15:0] s1_meas_ff, s1_targ_ff;
   logic               s1_start_ff;

   // loop state
   apl_pkg::pid_state_type pid_ff, pid_in, pid_nxt;
   logic signed [5:0]  held_ff, held_in;
   logic               landing_ff, landing_in;
   logic [13:0]        timer_ff, timer_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [5:0]  rsp_cmd_ff;
   logic               rsp_active_ff, rsp_lock_ff;

   logic               advance;
   logic               in_accept;
   logic               pid_run;
   logic signed [5:0]  pid_cmd;
   logic signed [5:0]  cmd;
   apl_pkg::land_type  land;

   // handshake
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || advance;
   assign in_accept   = req_tvalid && req_tready;
   assign s1_valid_in = in_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         alt_enable_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            apl_pkg::CSR_GAIN_P:     gain_p_ff     <= csr_wdata;
            apl_pkg::CSR_GAIN_I:     gain_i_ff     <= csr_wdata;
            apl_pkg::CSR_GAIN_D:     gain_d_ff     <= csr_wdata;
            apl_pkg::CSR_ALT_ENABLE: alt_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   apl_pid u_pid (
      .meas      (s1_meas_ff),
      .targ      (s1_targ_ff),
      .gain_p    (gain_p_ff),
      .gain_i    (gain_i_ff),
      .gain_d    (gain_d_ff),
      .state_cur (pid_ff),
      .state_nxt (pid_nxt),
      .cmd       (pid_cmd)
   );

   apl_land u_land (
      .flag_in   (landing_ff || s1_start_ff),
      .timer_cur (timer_ff),
      .meas      (s1_meas_ff),
      .land      (land)
   );

   // command select: hold above ceiling, landing override, enable gate
   always_comb begin
      pid_run = (s1_meas_ff <= apl_pkg::HOLD_ABOVE);
      cmd     = pid_run ? pid_cmd : held_ff;
      if (land.override) begin
         cmd = land.cmd;
      end
      if (!alt_enable_ff) begin
         cmd = '0;
      end
   end

   // next state
   always_comb begin
      pid_in     = pid_ff;
      held_in    = held_ff;
      landing_in = landing_ff;
      timer_in   = timer_ff;
      if (advance) begin
         if (pid_run) begin
            pid_in = pid_nxt;
         end
         held_in    = cmd;
         landing_in = land.active;
         timer_in   = land.timer;
      end
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pid_ff       <= '0;
         held_ff      <= '0;
         landing_ff   <= 1'b0;
         timer_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pid_ff       <= pid_in;
         held_ff      <= held_in;
         landing_ff   <= landing_in;
         timer_ff     <= timer_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_meas_ff  <= req_tdata[15:0];
         s1_targ_ff  <= req_tdata[31:16];
         s1_start_ff <= req_tuser;
      end
      if (advance) begin
         rsp_cmd_ff    <= cmd;
         rsp_active_ff <= land.active;
         rsp_lock_ff   <= land.lock;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_cmd_ff};
   assign rsp_tuser  = {rsp_lock_ff, rsp_active_ff};

   // checks
   `APL_ASSERT_IMPLY(a_lock_ends_landing, clock, reset, rsp_valid_ff && rsp_lock_ff, !rsp_active_ff)
   `APL_ASSERT_IMPLY(a_cmd_range, clock, reset, rsp_valid_ff, (rsp_cmd_ff >= apl_pkg::RATE_FAST) && (rsp_cmd_ff <= 6'sd20))
   `APL_ASSERT_NEXT(a_disabled_zero, clock, reset, advance && !alt_enable_ff, rsp_cmd_ff == 6'sd0)
   `APL_ASSERT_IMPLY(a_timer_idle, clock, reset, !landing_ff, timer_ff == 14'd0)
   `APL_ASSERT_IMPLY(a_timer_bound, clock, reset, 1'b1, timer_ff < apl_pkg::LAND_TIMEOUT_MS)

endmodule

@@ hdl/apl_pid.sv @@
// PID datapath: error, saturating accumulator, three products, clamps, Q8.8 truncation.
// Depends on apl_pkg.
`timescale 1ns / 1ps

module apl_pid (
   input  logic signed [15:0]      meas,
   input  logic signed [15:0]      targ,
   input  logic signed [15:0]      gain_p,
   input  logic signed [15:0]      gain_i,
   input  logic signed [15:0]      gain_d,
   input  apl_pkg::pid_state_type  state_cur,
   output apl_pkg::pid_state_type  state_nxt,
   output logic signed [5:0]       cmd
);

   logic signed [16:0] err;
   logic signed [32:0] sum_wide;
   logic signed [31:0] sum_sat;
   logic signed [17:0] err_diff;
   logic signed [32:0] p_term;
   logic signed [47:0] i_full;
   logic signed [12:0] i_term;
   logic signed [33:0] d_term;
   logic signed [34:0] total;
   logic signed [13:0] total_sat;
   logic        [13:0] mag;
   logic        [4:0]  mag_q;

   // error and saturating accumulator
   always_comb begin
      err      = 17'(targ) - 17'(meas);
      sum_wide = 33'(state_cur.error_sum) + 33'(err);
      if (sum_wide[32] != sum_wide[31]) begin
         sum_sat = sum_wide[32] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
      end else begin
         sum_sat = sum_wide[31:0];
      end
   end

   // the three products
   always_comb begin
      err_diff = 18'(err) - 18'(state_cur.prev_error);
      p_term   = 33'(gain_p) * 33'(err);
      i_full   = 48'(gain_i) * 48'(sum_sat);
      d_term   = 34'(gain_d) * 34'(err_diff);
   end

   // integral clamp, sum, output clamp
   always_comb begin
      if (i_full > 48'(apl_pkg::INTEG_LIM_Q)) begin
         i_term = apl_pkg::INTEG_LIM_Q;
      end else if (i_full < -48'(apl_pkg::INTEG_LIM_Q)) begin
         i_term = -apl_pkg::INTEG_LIM_Q;
      end else begin
         i_term = i_full[12:0];
      end
      total = 35'(p_term) + 35'(d_term) + 35'(i_term);
      if (total > 35'(apl_pkg::OUT_LIM_Q)) begin
         total_sat = apl_pkg::OUT_LIM_Q;
      end else if (total < -35'(apl_pkg::OUT_LIM_Q)) begin
         total_sat = -apl_pkg::OUT_LIM_Q;
      end else begin
         total_sat = total[13:0];
      end
   end

   // divide by 256, truncating toward zero
   always_comb begin
      mag   = total_sat[13] ? 14'(-total_sat) : 14'(total_sat);
      mag_q = mag[12:8];
      cmd   = total_sat[13] ? -$signed(6'({1'b0, mag_q})) : $signed(6'({1'b0, mag_q}));
   end

   assign state_nxt.prev_error = err;
   assign state_nxt.error_sum  = sum_sat;

endmodule

@@ hdl/apl_land.sv @@
// Auto-land sequencer: timer step, completion test and stepped descent rate.
// Depends on apl_pkg.
`timescale 1ns / 1ps

module apl_land (
   input  logic               flag_in,
   input  logic [13:0]        timer_cur,
   input  logic signed [15:0] meas,
   output apl_pkg::land_type  land
);

   logic [13:0] timer_step;

   assign timer_step = timer_cur + apl_pkg::LAND_STEP_MS;

   // completion wins over the descent table
   always_comb begin
      land.override = 1'b0;
      land.cmd      = '0;
      land.active   = 1'b0;
      land.lock     = 1'b0;
      land.timer    = timer_cur;
      if (flag_in) begin
         land.override = 1'b1;
         if (timer_step >= apl_pkg::LAND_TIMEOUT_MS || meas <= apl_pkg::LAND_DONE_HEIGHT) begin
            land.lock  = 1'b1;
            land.timer = '0;
         end else begin
            land.active = 1'b1;
            land.timer  = timer_step;
            if (meas >= apl_pkg::LAND_FAST_HEIGHT) begin
               land.cmd = apl_pkg::RATE_FAST;
            end else if (meas >= apl_pkg::LAND_MID_HEIGHT) begin
               land.cmd = apl_pkg::RATE_MID;
            end else begin
               land.cmd = apl_pkg::RATE_SLOW;
            end
         end
      end
   end

endmodule
